// ----- rtl/bis_pkg.sv -----
// Shared types and codes for the bitmap index and scan block.
`timescale 1ns / 1ps
package bis_pkg;

	localparam logic [1:0] OP_NEW_ROW  = 2'd0;
	localparam logic [1:0] OP_SET_ATTR = 2'd1;
	localparam logic [1:0] OP_FETCH    = 2'd2;
	localparam logic [1:0] OP_RESTART  = 2'd3;

	localparam logic [2:0] REG_TERM_COUNT = 3'd0;
	localparam logic [2:0] REG_TERM_A     = 3'd1;
	localparam logic [2:0] REG_TERM_B     = 3'd2;
	localparam logic [2:0] REG_TERM_C     = 3'd3;
	localparam logic [2:0] REG_TERM_D     = 3'd4;

	localparam int ROW_W  = 12;
	localparam int ATTR_W = 6;
	localparam int TERMS_HW = 4;

	typedef enum logic [2:0] {
		OSEL_NEW_ROW,
		OSEL_EMPTY_END,
		OSEL_PEND_MID,
		OSEL_PEND_LAST,
		OSEL_PEND_END
	} out_sel_t;

	typedef struct packed {
		logic     new_row;
		logic     set_attr;
		logic     restart;
		logic     fetch_init;
		logic     scan_read;
		logic     take_match;
		logic     finish;
		logic     out_load;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic cursor_done;
		logic scan_more;
		logic match;
		logic pend_v;
		logic batch_hit;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/bis_ctrl.sv -----
// Sequencer for row creation, attribute writes, cursor restart and the fetch scan.
`timescale 1ns / 1ps
module bis_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     op,
	input  bis_pkg::sts_t  sts,
	output bis_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CHECK,
		ST_LAST,
		ST_FINISH
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd      = '0;
		cmd.out_sel = bis_pkg::OSEL_NEW_ROW;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = sts.out_free;
				if (in_valid && sts.out_free) begin
					unique case (op)
						bis_pkg::OP_NEW_ROW: begin
							cmd.new_row  = 1'b1;
							cmd.out_load = 1'b1;
							cmd.out_sel  = bis_pkg::OSEL_NEW_ROW;
						end
						bis_pkg::OP_SET_ATTR: cmd.set_attr = 1'b1;
						bis_pkg::OP_RESTART:  cmd.restart = 1'b1;
						bis_pkg::OP_FETCH: begin
							if (sts.cursor_done) begin
								cmd.out_load = 1'b1;
								cmd.out_sel  = bis_pkg::OSEL_EMPTY_END;
							end else begin
								cmd.fetch_init = 1'b1;
								state_d = ST_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				if (sts.scan_more) begin
					cmd.scan_read = 1'b1;
					state_d = ST_CHECK;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_CHECK: begin
				if (!sts.match) begin
					state_d = ST_SCAN;
				end else if (!sts.pend_v || sts.out_free) begin
					// emit the held match, hold the new one until the next is known
					cmd.take_match = 1'b1;
					cmd.out_load = sts.pend_v;
					cmd.out_sel  = bis_pkg::OSEL_PEND_MID;
					state_d = sts.batch_hit ? ST_LAST : ST_SCAN;
				end
			end
			ST_LAST: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_sel  = bis_pkg::OSEL_PEND_LAST;
					state_d = ST_IDLE;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish   = 1'b1;
					cmd.out_load = 1'b1;
					cmd.out_sel  = sts.pend_v ? bis_pkg::OSEL_PEND_END
						: bis_pkg::OSEL_EMPTY_END;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free) else $error("result loaded over a waiting beat");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE) else $error("input taken during a scan");
	a_read_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_read |=> state_q == ST_CHECK) else $error("read data not checked");

endmodule

// ----- rtl/bis_dp.sv -----
// Bitmap store, row and cursor counters, query mask and result register.
`timescale 1ns / 1ps
module bis_dp #(
	parameter int NUM_ATTRS = 64,
	parameter int NUM_ROWS  = 4096,
	parameter int MAX_TERMS = 4,
	parameter int MAX_BATCH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [bis_pkg::ATTR_W-1:0]  cfg_data,
	input  logic [bis_pkg::ATTR_W-1:0]  attribute,
	input  logic [4:0]                  max_count,
	input  bis_pkg::cmd_t               cmd,
	output bis_pkg::sts_t               sts,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bis_pkg::ROW_W-1:0]   row,
	output logic                        found,
	output logic                        at_end,
	output logic                        full_res,
	output logic                        last
);

	localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int AW = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;
	localparam int CW = $clog2(MAX_BATCH + 1);
	localparam int TERM_LIM = (MAX_TERMS < bis_pkg::TERMS_HW) ? MAX_TERMS : bis_pkg::TERMS_HW;

	logic [NUM_ATTRS-1:0] mem [NUM_ROWS];

	logic [2:0]                 term_count_q;
	logic [bis_pkg::ATTR_W-1:0] term_q [bis_pkg::TERMS_HW];
	logic [RW:0]                row_count_q;
	logic [RW:0]                cursor_q;
	logic                       cursor_done_q;
	logic [NUM_ATTRS-1:0]       cur_bits_q;
	logic [NUM_ATTRS-1:0]       mask_q;
	logic                       possible_q;
	logic [CW-1:0]              lim_q;
	logic [CW-1:0]              count_q;
	logic [NUM_ATTRS-1:0]       rd_q;
	logic [RW:0]                scan_row_q;
	logic [RW:0]                pend_row_q;
	logic                       pend_v_q;
	logic                       out_valid_q;
	logic [bis_pkg::ROW_W-1:0]  row_q;
	logic                       found_q, at_end_q, full_q, last_q;

	logic                 store_full;
	logic                 attr_ok;
	logic [RW:0]          cur_row;
	logic [NUM_ATTRS-1:0] set_bits;
	logic [NUM_ATTRS-1:0] mask_d;
	logic                 possible_d;
	logic [CW-1:0]        lim_d;
	logic [2:0]           nterms;

	assign store_full = (row_count_q == (RW + 1)'(NUM_ROWS));
	assign attr_ok    = (32'(attribute) < NUM_ATTRS) && (row_count_q != '0);
	assign cur_row    = row_count_q - 1'b1;
	assign set_bits   = cur_bits_q | ({{(NUM_ATTRS-1){1'b0}}, 1'b1} << AW'(attribute));

	always_comb begin
		nterms = term_count_q;
		if (nterms == 3'd0) nterms = 3'd1;
		if (32'(nterms) > TERM_LIM) nterms = 3'(TERM_LIM);
		mask_d     = '0;
		possible_d = 1'b1;
		for (int i = 0; i < bis_pkg::TERMS_HW; i++) begin
			if (i < 32'(nterms)) begin
				if (32'(term_q[i]) >= NUM_ATTRS) possible_d = 1'b0;
				else mask_d[AW'(term_q[i])] = 1'b1;
			end
		end
		if (max_count == 5'd0) lim_d = CW'(1);
		else if (32'(max_count) > MAX_BATCH) lim_d = CW'(MAX_BATCH);
		else lim_d = CW'(max_count);
	end

	// Each new row clears its word, so only created rows are ever read.
	always_ff @(posedge clk) begin
		if (cmd.new_row && !store_full) begin
			mem[row_count_q[RW-1:0]] <= '0;
		end else if (cmd.set_attr && attr_ok) begin
			mem[cur_row[RW-1:0]] <= set_bits;
		end
		if (cmd.scan_read) begin
			rd_q <= mem[cursor_q[RW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		// a refused new row keeps the last row current
		if (cmd.new_row && !store_full) cur_bits_q <= '0;
		else if (cmd.set_attr && attr_ok) cur_bits_q <= set_bits;
		if (cmd.fetch_init) mask_q <= mask_d;
		if (cmd.scan_read) scan_row_q <= cursor_q;
		if (cmd.take_match) pend_row_q <= scan_row_q;
		if (cmd.out_load) begin
			row_q    <= '0;
			found_q  <= 1'b0;
			at_end_q <= 1'b0;
			full_q   <= 1'b0;
			last_q   <= 1'b1;
			case (cmd.out_sel)
				bis_pkg::OSEL_NEW_ROW: begin
					if (store_full) begin
						full_q <= 1'b1;
					end else begin
						row_q   <= bis_pkg::ROW_W'(row_count_q);
						found_q <= 1'b1;
					end
				end
				bis_pkg::OSEL_EMPTY_END: at_end_q <= 1'b1;
				bis_pkg::OSEL_PEND_MID: begin
					row_q   <= bis_pkg::ROW_W'(pend_row_q);
					found_q <= 1'b1;
					last_q  <= 1'b0;
				end
				bis_pkg::OSEL_PEND_LAST: begin
					row_q   <= bis_pkg::ROW_W'(pend_row_q);
					found_q <= 1'b1;
				end
				bis_pkg::OSEL_PEND_END: begin
					row_q    <= bis_pkg::ROW_W'(pend_row_q);
					found_q  <= 1'b1;
					at_end_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q  <= 3'd1;
			for (int i = 0; i < bis_pkg::TERMS_HW; i++) term_q[i] <= '0;
			row_count_q   <= '0;
			cursor_q      <= '0;
			cursor_done_q <= 1'b0;
			possible_q    <= 1'b0;
			lim_q         <= CW'(1);
			count_q       <= '0;
			pend_v_q      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					bis_pkg::REG_TERM_COUNT: term_count_q <= cfg_data[2:0];
					bis_pkg::REG_TERM_A:     term_q[0] <= cfg_data;
					bis_pkg::REG_TERM_B:     term_q[1] <= cfg_data;
					bis_pkg::REG_TERM_C:     term_q[2] <= cfg_data;
					bis_pkg::REG_TERM_D:     term_q[3] <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.new_row && !store_full) row_count_q <= row_count_q + 1'b1;
			if (cmd.restart) begin
				cursor_q      <= '0;
				cursor_done_q <= 1'b0;
			end else if (cmd.scan_read) begin
				cursor_q <= cursor_q + 1'b1;
			end else if (cmd.finish) begin
				cursor_done_q <= 1'b1;
				if (cursor_q < row_count_q) cursor_q <= row_count_q;
			end
			if (cmd.fetch_init) begin
				possible_q <= possible_d;
				lim_q      <= lim_d;
				count_q    <= '0;
				pend_v_q   <= 1'b0;
			end else if (cmd.take_match) begin
				count_q  <= count_q + 1'b1;
				pend_v_q <= 1'b1;
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.cursor_done = cursor_done_q;
		sts.scan_more   = possible_q && (cursor_q < row_count_q);
		sts.match       = ((rd_q & mask_q) == mask_q);
		sts.pend_v      = pend_v_q;
		sts.batch_hit   = ((count_q + 1'b1) == lim_q);
		sts.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign row       = row_q;
	assign found     = found_q;
	assign at_end    = at_end_q;
	assign full_res  = full_q;
	assign last      = last_q;

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= row_count_q) else $error("cursor past the row count");
	a_rows_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_count_q <= (RW + 1)'(NUM_ROWS)) else $error("row count past the store");
	a_batch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lim_q) else $error("more matches than the batch allows");

endmodule

// ----- rtl/bitmap_index_and_scan_top.sv -----
// Bitmap index with an AND-scan cursor: top level.
`timescale 1ns / 1ps
// New-row, set-attribute and restart items complete in the accepting cycle;
// new-row gives one result beat. A fetch examines each row by a registered
// read of the single-port row store in ST_SCAN, then a mask compare in
// ST_CHECK, and closes through ST_LAST when the batch fills, or ST_FINISH
// when the rows run out; a fetch on a finished cursor gives only an end beat.
// A beat held back by out_ready stalls the scan at a closing state or the
// next match, so the length depends on how far the cursor must walk to find
// max_count matches. The store needs no clearing pass: each new row zeroes its
// own word. While a result beat waits on out_ready, no new input is taken.
// Config writes are always accepted and must only come while the block is idle.
module bitmap_index_and_scan_top #(
	parameter int NUM_ATTRS = 64,
	parameter int NUM_ROWS  = 4096,
	parameter int MAX_TERMS = 4,
	parameter int MAX_BATCH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [5:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [5:0]  attribute,
	input  logic [4:0]  max_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] row,
	output logic        found,
	output logic        at_end,
	output logic        full_res,
	output logic        last
);

	bis_pkg::cmd_t cmd;
	bis_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	bis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.sts      (sts),
		.cmd      (cmd)
	);

	bis_dp #(
		.NUM_ATTRS (NUM_ATTRS),
		.NUM_ROWS  (NUM_ROWS),
		.MAX_TERMS (MAX_TERMS),
		.MAX_BATCH (MAX_BATCH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.attribute (attribute),
		.max_count (max_count),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.row       (row),
		.found     (found),
		.at_end    (at_end),
		.full_res  (full_res),
		.last      (last)
	);

endmodule
